// File: hw/rtl/first_match_exit_rule_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// Exit rule classifier assertion macros
// Shorthand for clocked implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_EXIT_RULE_CLASSIFIER_TOP_ASSERT_SVH
`define FIRST_MATCH_EXIT_RULE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FMC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FMC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fmc_pkg.sv
// ----------------------------------------------------------------------------
// Exit rule classifier package
// Item and rule types, operation and status codes, and the decode helpers.
// ----------------------------------------------------------------------------
package fmc_pkg;

  localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [1:0] FUNC_APPEND  = 2'd1;
  localparam logic [1:0] FUNC_PREPEND = 2'd2;

  localparam logic [1:0] FAM_ANY = 2'd0;
  localparam logic [1:0] FAM_V4  = 2'd1;
  localparam logic [1:0] FAM_V6  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam logic [7:0] V4_PREFIX_MAX = 8'd32;
  localparam logic [7:0] V6_PREFIX_MAX = 8'd128;
  localparam logic [7:0] HALF_BITS     = 8'd64;

  localparam int IDX_W = 6;

  localparam logic [7:0] V6_ULA_MASK = 8'hFE;
  localparam logic [7:0] V6_ULA_PFX  = 8'hFC;
  localparam logic [7:0] V6_LL_BYTE  = 8'hFE;
  localparam logic [7:0] V6_LL_MASK  = 8'hC0;
  localparam logic [7:0] V6_LL_PFX   = 8'h80;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  pfx_len;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic        accept;
    logic [15:0] query_port;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             allowed;
    logic             private_hit;
    logic             matched;
    logic [IDX_W-1:0] match_index;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  family;
    logic [7:0]  pfx_len;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic        accept;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
  } rule_t;

  typedef struct packed {
    logic [1:0]  family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
  } qry_t;

  // Private and loopback ranges; only IPv4 and IPv6 queries are checked.
  function automatic logic is_private(input logic [1:0] fam, input logic [63:0] hi,
                                      input logic [63:0] lo);
    logic [31:0] a;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        v4;
    logic        v6;
    a  = lo[31:0];
    b0 = hi[63:56];
    b1 = hi[55:48];
    v4 = (a[31:24] == 8'h0A) || (a[31:20] == 12'hAC1) ||
         (a[31:16] == 16'hC0A8) || (a[31:24] == 8'h7F);
    v6 = ((hi == 64'd0) && (lo == 64'd1)) ||
         ((b0 & V6_ULA_MASK) == V6_ULA_PFX) ||
         ((b0 == V6_LL_BYTE) && ((b1 & V6_LL_MASK) == V6_LL_PFX));
    if (fam == FAM_V4) begin
      return v4;
    end else if (fam == FAM_V6) begin
      return v6;
    end
    return 1'b0;
  endfunction

  // A rule is rejected for an unknown family, an empty port range or a
  // prefix longer than its address.
  function automatic logic is_bad_rule(input logic [1:0] fam, input logic [7:0] pl,
                                       input logic [15:0] plo, input logic [15:0] phi);
    return (fam != FAM_ANY && fam != FAM_V4 && fam != FAM_V6) || (plo > phi) ||
           (fam == FAM_V4 && pl > V4_PREFIX_MAX) ||
           (fam == FAM_V6 && pl > V6_PREFIX_MAX);
  endfunction

endpackage

// File: hw/rtl/fmc_rule_mem.sv
// ----------------------------------------------------------------------------
// Rule store
// One write port and one registered read port over the circular rule table.
// ----------------------------------------------------------------------------
module fmc_rule_mem
  import fmc_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  rule_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output rule_t             rd_data
);

  rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/fmc_rule_match.sv
// ----------------------------------------------------------------------------
// Rule compare unit
// Checks one stored rule against the held query: family, prefix and port.
// ----------------------------------------------------------------------------
module fmc_rule_match
  import fmc_pkg::*;
(
  input  rule_t rule,
  input  qry_t  qry,
  output logic  hit
);

  logic [31:0] mask_v4;
  logic [63:0] mask_hi;
  logic [63:0] mask_lo;
  logic [7:0]  lo_len;
  logic        addr_ok;
  logic        port_ok;

  // Shifting all ones right by the prefix length and inverting gives the
  // leading-ones mask; shifts of the full width or more saturate to all ones.
  always_comb begin
    mask_v4 = ~(32'hFFFF_FFFF >> rule.pfx_len);
    mask_hi = ~({64{1'b1}} >> rule.pfx_len);
    lo_len  = rule.pfx_len - HALF_BITS;
    mask_lo = (rule.pfx_len > HALF_BITS) ? ~({64{1'b1}} >> lo_len) : '0;
    case (rule.family)
      FAM_ANY: begin
        addr_ok = 1'b1;
      end
      FAM_V4: begin
        addr_ok = (qry.family == FAM_V4) &&
                  ((qry.addr_lo[31:0] & mask_v4) == (rule.addr_lower[31:0] & mask_v4));
      end
      FAM_V6: begin
        addr_ok = (qry.family == FAM_V6) &&
                  ((qry.addr_hi & mask_hi) == (rule.addr_upper & mask_hi)) &&
                  ((qry.addr_lo & mask_lo) == (rule.addr_lower & mask_lo));
      end
      default: begin
        addr_ok = 1'b0;
      end
    endcase
    port_ok = (qry.port >= rule.port_low) && (qry.port <= rule.port_high);
    hit     = addr_ok && port_ok;
  end

endmodule

// File: hw/rtl/first_match_exit_rule_classifier_top.sv
// ----------------------------------------------------------------------------
// First-match exit rule classifier
// Ordered exit rule table with append, prepend and first-match lookup.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req channel (req_valid, req_stall, req) and each
// one gives exactly one item on the rsp channel (rsp_valid, rsp_stall, rsp).
// An item is taken at a rising edge where valid is high and stall is low.
// Appends, prepends, unused operations and lookups that hit a private range
// or find an empty table need no walk: the response item is valid on
// the cycle after the request is taken.
// Any other lookup walks the table in rule order, reading one rule per cycle
// from the rule store's read port and checking it in the single compare
// unit. A lookup stops early on the first match and otherwise ends after
// the last rule comes back.
// The block takes one item at a time: req_stall is high during a walk, and
// also while an earlier response item is held and the receiver stalls it.
// Reset empties the table (rule count and head slot go to zero) and drops
// any held response; the rule store itself is not cleared, because only
// slots that hold counted rules are ever read.
// ----------------------------------------------------------------------------
`include "first_match_exit_rule_classifier_top_assert.svh"

module first_match_exit_rule_classifier_top
  import fmc_pkg::*;
#(
  parameter int MAX_RULES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SLOT_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W  = $clog2(MAX_RULES + 1);
  localparam int SUM_W  = CNT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t state;

  // Table bookkeeping: the rules live in a circular store starting at head.
  logic [CNT_W-1:0]  rule_count;
  logic [SLOT_W-1:0] head_slot;

  // Walk pointers: issue side addresses the store, rd side tags the data
  // that comes back in the next cycle.
  logic [SLOT_W-1:0] issue_slot;
  logic [CNT_W-1:0]  issue_pos;
  logic              issued_all;
  logic              rd_valid;
  logic [CNT_W-1:0]  rd_pos;
  logic              rd_last;
  qry_t              qry;

  logic              take_req;
  logic              req_priv;
  logic              req_bad;
  logic              tbl_full;
  logic              is_insert;
  logic              do_insert;
  logic              start_walk;
  logic              quick_done;
  logic              issue;
  logic              hit;
  logic              walk_hit;
  logic              walk_end;
  logic [SUM_W-1:0]  append_sum;
  logic [SLOT_W-1:0] append_slot;
  logic [SLOT_W-1:0] prepend_slot;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] issue_slot_next;
  rule_t             new_rule;
  rule_t             rd_rule;
  rsp_t              quick_rsp;
  rsp_t              walk_rsp;

  // A new item is taken only between walks and when the response register
  // is free or is being emptied in this same cycle.
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign take_req  = req_valid && !req_stall;

  always_comb begin
    req_priv  = is_private(req.family, req.addr_hi, req.addr_lo);
    req_bad   = is_bad_rule(req.family, req.pfx_len, req.port_low, req.port_high);
    tbl_full  = (rule_count == CNT_W'(MAX_RULES));
    is_insert = (req.func == FUNC_APPEND) || (req.func == FUNC_PREPEND);
    do_insert = take_req && is_insert && !req_bad && !tbl_full;

    // Head plus count stays below twice the table size, so one compare and
    // subtract wraps it.
    append_sum = SUM_W'(head_slot) + SUM_W'(rule_count);
    if (append_sum >= SUM_W'(MAX_RULES)) begin
      append_slot = SLOT_W'(append_sum - SUM_W'(MAX_RULES));
    end else begin
      append_slot = SLOT_W'(append_sum);
    end
    if (head_slot == '0) begin
      prepend_slot = SLOT_W'(MAX_RULES - 1);
    end else begin
      prepend_slot = head_slot - 1'b1;
    end
    wr_slot = (req.func == FUNC_APPEND) ? append_slot : prepend_slot;

    new_rule.family     = req.family;
    new_rule.pfx_len    = req.pfx_len;
    new_rule.port_low   = req.port_low;
    new_rule.port_high  = req.port_high;
    new_rule.accept     = req.accept;
    new_rule.addr_upper = (req.family == FAM_V6) ? req.addr_hi : '0;
    new_rule.addr_lower = (req.family == FAM_V4) ? {32'd0, req.addr_lo[31:0]} : req.addr_lo;

    start_walk = take_req && (req.func == FUNC_LOOKUP) && !req_priv && (rule_count != '0);
    quick_done = take_req && !start_walk;

    quick_rsp             = '0;
    quick_rsp.private_hit = (req.func == FUNC_LOOKUP) && req_priv;
    if (is_insert) begin
      if (req_bad) begin
        quick_rsp.status = STAT_BAD;
      end else if (tbl_full) begin
        quick_rsp.status = STAT_FULL;
      end else begin
        quick_rsp.status = STAT_OK;
      end
    end

    issue = (state == S_WALK) && !issued_all;
    if (issue_slot == SLOT_W'(MAX_RULES - 1)) begin
      issue_slot_next = '0;
    end else begin
      issue_slot_next = issue_slot + 1'b1;
    end

    // The walk ends at the first hit or after the last rule comes back.
    walk_hit = (state == S_WALK) && rd_valid && hit;
    walk_end = walk_hit || ((state == S_WALK) && rd_valid && rd_last);

    walk_rsp             = '0;
    walk_rsp.status      = STAT_OK;
    walk_rsp.matched     = walk_hit;
    walk_rsp.allowed     = walk_hit && rd_rule.accept;
    walk_rsp.match_index = walk_hit ? IDX_W'(rd_pos) : '0;
  end

  fmc_rule_mem #(
    .DEPTH  (MAX_RULES),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (do_insert),
    .wr_addr (wr_slot),
    .wr_data (new_rule),
    .rd_en   (issue),
    .rd_addr (issue_slot),
    .rd_data (rd_rule)
  );

  fmc_rule_match u_match (
    .rule (rd_rule),
    .qry  (qry),
    .hit  (hit)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rule_count <= '0;
      head_slot  <= '0;
      issue_slot <= '0;
      issue_pos  <= '0;
      issued_all <= 1'b0;
      rd_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_valid <= issue;
      case (state)
        S_IDLE: begin
          if (start_walk) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (do_insert) begin
        rule_count <= rule_count + 1'b1;
        if (req.func == FUNC_PREPEND) begin
          head_slot <= prepend_slot;
        end
      end

      if (start_walk) begin
        issue_slot <= head_slot;
        issue_pos  <= '0;
        issued_all <= 1'b0;
      end else if (issue) begin
        issue_slot <= issue_slot_next;
        issue_pos  <= issue_pos + 1'b1;
        issued_all <= (issue_pos == rule_count - 1'b1);
      end

      if (quick_done || walk_end) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start_walk) begin
      qry.family  <= req.family;
      qry.addr_hi <= req.addr_hi;
      qry.addr_lo <= req.addr_lo;
      qry.port    <= req.query_port;
    end
    if (issue) begin
      rd_pos  <= issue_pos;
      rd_last <= (issue_pos == rule_count - 1'b1);
    end
    if (quick_done) begin
      rsp <= quick_rsp;
    end else if (walk_end) begin
      rsp <= walk_rsp;
    end
  end

  `FMC_ASSERT_IMP(a_stall_in_walk, state == S_WALK, req_stall,
                  "request taken during a table walk")
  `FMC_ASSERT_NXT(a_hit_reported, walk_hit, rsp_valid && rsp.matched,
                  "first matching rule not reported")
  `FMC_ASSERT_NXT(a_insert_counts, do_insert, rule_count == $past(rule_count) + 1'b1,
                  "accepted insert did not grow the table")

endmodule
